FILE: rtl/efbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package efbd_pkg;

   // field widths of one received byte and one result word
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int LEN_W   = 7;
   localparam int CODE_W  = 2;
   localparam int TALLY_W = 16;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] CSR_CAPACITY    = 2'd0;
   localparam logic [1:0] CSR_START_CODE  = 2'd1;
   localparam logic [1:0] CSR_END_CODE    = 2'd2;
   localparam logic [1:0] CSR_ESCAPE_CODE = 2'd3;

   localparam logic [LEN_W-1:0]  CAPACITY_RST    = 7'd64;
   localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'd1;
   localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'd4;
   localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd27;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [CODE_W-1:0] ERR_START  = 2'd0;
   localparam logic [CODE_W-1:0] ERR_OVER   = 2'd1;
   localparam logic [CODE_W-1:0] ERR_ESCAPE = 2'd2;

   // parser states
   localparam logic [1:0] PS_IDLE  = 2'd0;
   localparam logic [1:0] PS_FRAME = 2'd1;
   localparam logic [1:0] PS_ESC   = 2'd2;

   // sequencer states
   localparam logic SEQ_PARSE = 1'b0;
   localparam logic SEQ_DUMP  = 1'b1;

   localparam logic [TALLY_W-1:0] TALLY_MAX = 16'hFFFF;

endpackage

`default_nettype wire

FILE: rtl/escape_framed_byte_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte deframer for start/end/escape framed links. Each received word is one
// byte; bytes outside a frame are ignored until the start code. Payload bytes
// go into an on-chip frame buffer (BUFFER_DEPTH bytes, one write port, one
// read port with a registered read). A received byte is taken whenever the
// result register is free and no readout runs; a byte that needs no result
// leaves the input free for the next byte. On the end code the buffer is read
// back through the read register and the result register, one word per cycle
// while the result side does not stall, and the input is held off until the
// readout ends. Errors (start code inside a frame, buffer over capacity,
// non-control byte after the escape code) give a single error word, empty the
// buffer and count up a saturating 16-bit error total that rides on every
// result word. The frame buffer needs no clearing after reset: only entries
// written in the current frame are read back.
module escape_framed_byte_deframer #(
   parameter int BUFFER_DEPTH = 64
) (
   input  wire                                 clock,
   input  wire                                 reset,

   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [efbd_pkg::BYTE_W-1:0]         req_rx_byte,

   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [efbd_pkg::KIND_W-1:0]         rsp_kind,
   output logic [efbd_pkg::BYTE_W-1:0]         rsp_payload,
   output logic                                rsp_last,
   output logic [efbd_pkg::LEN_W-1:0]          rsp_frame_length,
   output logic [efbd_pkg::CODE_W-1:0]         rsp_fault_code,
   output logic [efbd_pkg::TALLY_W-1:0]        rsp_error_total,

   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [efbd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire  [efbd_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [efbd_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import efbd_pkg::*;

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUFFER_DEPTH);

   // configuration registers
   logic [LEN_W-1:0]  capacity_ff;
   logic [BYTE_W-1:0] start_code_ff;
   logic [BYTE_W-1:0] end_code_ff;
   logic [BYTE_W-1:0] escape_code_ff;

   // control state
   logic               seq_ff, seq_in;
   logic [1:0]         parse_ff, parse_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // readout bookkeeping
   logic [AW-1:0]      out_idx_ff, out_idx_in;
   logic [LEN_W-1:0]   dump_len_ff, dump_len_in;

   // result register
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]  rsp_payload_ff, rsp_payload_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [CODE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic [TALLY_W-1:0] rsp_total_ff, rsp_total_in;
   logic               out_load;

   // frame buffer
   logic [BYTE_W-1:0]  frame_mem [BUFFER_DEPTH];
   logic [BYTE_W-1:0]  mem_q_ff;
   logic               mem_we;
   logic               mem_re;
   logic [AW-1:0]      rd_addr;

   logic               csr_write;
   logic               req_accept;
   logic               out_free;
   logic [LEN_W-1:0]   eff_cap;
   logic               is_control;
   logic               fits;
   logic               err_raise;
   logic [CODE_W-1:0]  err_code;
   logic [TALLY_W-1:0] tally_inc;
   logic [LEN_W-1:0]   idx_next;

   // ---------------------------------------------------------------- config
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= CAPACITY_RST;
         start_code_ff  <= START_CODE_RST;
         end_code_ff    <= END_CODE_RST;
         escape_code_ff <= ESCAPE_CODE_RST;
      end else if (csr_write) begin
         case (paddr[3:2])
            CSR_CAPACITY:    capacity_ff    <= pwdata[LEN_W-1:0];
            CSR_START_CODE:  start_code_ff  <= pwdata[BYTE_W-1:0];
            CSR_END_CODE:    end_code_ff    <= pwdata[BYTE_W-1:0];
            CSR_ESCAPE_CODE: escape_code_ff <= pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_CAPACITY:    prdata = CSR_DATA_W'(capacity_ff);
         CSR_START_CODE:  prdata = CSR_DATA_W'(start_code_ff);
         CSR_END_CODE:    prdata = CSR_DATA_W'(end_code_ff);
         CSR_ESCAPE_CODE: prdata = CSR_DATA_W'(escape_code_ff);
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- control
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (seq_ff != SEQ_PARSE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   assign eff_cap    = (capacity_ff > DEPTH_LEN) ? DEPTH_LEN : capacity_ff;
   assign fits       = fill_ff < eff_cap;
   assign is_control = (req_rx_byte == start_code_ff) || (req_rx_byte == end_code_ff)
                       || (req_rx_byte == escape_code_ff);
   assign tally_inc  = (tally_ff != TALLY_MAX) ? tally_ff + TALLY_W'(1) : tally_ff;
   assign idx_next   = LEN_W'(out_idx_ff) + LEN_W'(1);

   always_comb begin
      seq_in         = seq_ff;
      parse_in       = parse_ff;
      fill_in        = fill_ff;
      tally_in       = tally_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      out_idx_in     = out_idx_ff;
      dump_len_in    = dump_len_ff;
      out_load       = 1'b0;
      rsp_kind_in    = KIND_BYTE;
      rsp_payload_in = '0;
      rsp_last_in    = 1'b0;
      rsp_len_in     = '0;
      rsp_code_in    = ERR_START;
      rsp_total_in   = tally_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      rd_addr        = '0;
      err_raise      = 1'b0;
      err_code       = ERR_START;

      case (seq_ff)
         SEQ_PARSE: begin
            if (req_accept) begin
               case (parse_ff)
                  PS_FRAME: begin
                     if (req_rx_byte == start_code_ff) begin
                        parse_in  = PS_IDLE;
                        err_raise = 1'b1;
                        err_code  = ERR_START;
                     end else if (req_rx_byte == end_code_ff) begin
                        parse_in = PS_IDLE;
                        fill_in  = '0;
                        if (fill_ff == '0) begin
                           out_load    = 1'b1;
                           rsp_kind_in = KIND_EMPTY;
                           rsp_last_in = 1'b1;
                        end else begin
                           // start readout: fetch the first byte now
                           seq_in      = SEQ_DUMP;
                           mem_re      = 1'b1;
                           rd_addr     = '0;
                           out_idx_in  = '0;
                           dump_len_in = fill_ff;
                        end
                     end else if (req_rx_byte == escape_code_ff) begin
                        parse_in = PS_ESC;
                     end else if (fits) begin
                        mem_we  = 1'b1;
                        fill_in = fill_ff + LEN_W'(1);
                     end else begin
                        err_raise = 1'b1;
                        err_code  = ERR_OVER;
                     end
                  end
                  PS_ESC: begin
                     if (is_control) begin
                        parse_in = PS_FRAME;
                        if (fits) begin
                           mem_we  = 1'b1;
                           fill_in = fill_ff + LEN_W'(1);
                        end else begin
                           err_raise = 1'b1;
                           err_code  = ERR_OVER;
                        end
                     end else begin
                        // stay waiting for a control byte
                        err_raise = 1'b1;
                        err_code  = ERR_ESCAPE;
                     end
                  end
                  default: begin
                     parse_in = (req_rx_byte == start_code_ff) ? PS_FRAME : PS_IDLE;
                  end
               endcase
            end
         end
         SEQ_DUMP: begin
            if (out_free) begin
               out_load       = 1'b1;
               rsp_kind_in    = KIND_BYTE;
               rsp_payload_in = mem_q_ff;
               rsp_len_in     = dump_len_ff;
               rsp_last_in    = (idx_next == dump_len_ff);
               if (idx_next == dump_len_ff) begin
                  seq_in = SEQ_PARSE;
               end else begin
                  mem_re     = 1'b1;
                  rd_addr    = idx_next[AW-1:0];
                  out_idx_in = idx_next[AW-1:0];
               end
            end
         end
         default: begin
            seq_in = SEQ_PARSE;
         end
      endcase

      if (err_raise) begin
         fill_in      = '0;
         tally_in     = tally_inc;
         out_load     = 1'b1;
         rsp_kind_in  = KIND_ERROR;
         rsp_last_in  = 1'b1;
         rsp_code_in  = err_code;
         rsp_total_in = tally_inc;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_PARSE;
         parse_ff     <= PS_IDLE;
         fill_ff      <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         parse_ff     <= parse_in;
         fill_ff      <= fill_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_idx_ff  <= out_idx_in;
      dump_len_ff <= dump_len_in;
      if (out_load) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_last_ff    <= rsp_last_in;
         rsp_len_ff     <= rsp_len_in;
         rsp_code_ff    <= rsp_code_in;
         rsp_total_ff   <= rsp_total_in;
      end
   end

   // ---------------------------------------------------------------- buffer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[fill_ff[AW-1:0]] <= req_rx_byte;
      end
      if (mem_re) begin
         mem_q_ff <= frame_mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_payload      = rsp_payload_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_frame_length = rsp_len_ff;
   assign rsp_fault_code   = rsp_code_ff;
   assign rsp_error_total  = rsp_total_ff;

   // ---------------------------------------------------------------- checks
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_LEN)
      else $error("frame buffer fill past its depth");

   a_dump_clean: assert property (@(posedge clock) disable iff (reset)
      seq_ff == SEQ_DUMP |-> fill_ff == '0 && parse_ff == PS_IDLE)
      else $error("readout with parser not reset");

   a_dump_index: assert property (@(posedge clock) disable iff (reset)
      seq_ff == SEQ_DUMP |-> LEN_W'(out_idx_ff) < dump_len_ff)
      else $error("readout index past frame length");

   a_tally_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> tally_ff >= $past(tally_ff))
      else $error("error total went down");

endmodule

`default_nettype wire

FILE: dv/escape_framed_byte_deframer_tb.sv
`timescale 1ns / 1ps

module escape_framed_byte_deframer_tb;
   import efbd_pkg::*;

   localparam int BUF_DEPTH    = 64;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_LIMIT  = 30;
   localparam logic [CODE_W-1:0] NO_CODE = '0;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  payload;
      logic               last;
      logic [LEN_W-1:0]   length;
      logic [CODE_W-1:0]  code;
      logic [TALLY_W-1:0] total;
   } frame_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_W-1:0]     rsp_kind;
   logic [BYTE_W-1:0]     rsp_payload;
   logic                  rsp_last;
   logic [LEN_W-1:0]      rsp_frame_length;
   logic [CODE_W-1:0]     rsp_fault_code;
   logic [TALLY_W-1:0]    rsp_error_total;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // deframer state as predicted
   logic [LEN_W-1:0]   cfg_cap;
   logic [BYTE_W-1:0]  cfg_soh;
   logic [BYTE_W-1:0]  cfg_eot;
   logic [BYTE_W-1:0]  cfg_esc;
   logic [1:0]         parse_st;
   logic [BYTE_W-1:0]  frame_bytes [BUF_DEPTH];
   int                 fill_level;
   logic [TALLY_W-1:0] err_total;

   frame_word_type frame_words_due[$];
   frame_word_type due_word;
   int          busy_items = 0;
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_cycles = 0;

   escape_framed_byte_deframer #(.BUFFER_DEPTH(BUF_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_payload(rsp_payload), .rsp_last(rsp_last),
      .rsp_frame_length(rsp_frame_length), .rsp_fault_code(rsp_fault_code),
      .rsp_error_total(rsp_error_total),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic frame_word_type make_word(logic [KIND_W-1:0] kind,
                                                logic [BYTE_W-1:0] payload,
                                                logic last, logic [LEN_W-1:0] length,
                                                logic [CODE_W-1:0] code);
      frame_word_type w;
      w.kind    = kind;
      w.payload = payload;
      w.last    = last;
      w.length  = length;
      w.code    = code;
      w.total   = err_total;
      return w;
   endfunction

   function automatic bit is_ctrl(logic [BYTE_W-1:0] b);
      return b == cfg_soh || b == cfg_eot || b == cfg_esc;
   endfunction

   function automatic int room_limit();
      return (cfg_cap > BUF_DEPTH) ? BUF_DEPTH : int'(cfg_cap);
   endfunction

   function automatic void flag_error(logic [CODE_W-1:0] code);
      fill_level = 0;
      if (err_total != TALLY_MAX)
         err_total++;
      frame_words_due.push_back(make_word(KIND_ERROR, '0, 1'b1, '0, code));
   endfunction

   function automatic bit buffer_byte(logic [BYTE_W-1:0] b);
      if (fill_level >= room_limit())
         return 1'b0;
      frame_bytes[fill_level] = b;
      fill_level++;
      return 1'b1;
   endfunction

   function automatic void deframe_byte(logic [BYTE_W-1:0] b);
      if (parse_st != PS_IDLE || b == cfg_soh)
         busy_items++;
      case (parse_st)
         PS_FRAME: begin
            if (b == cfg_soh) begin
               parse_st = PS_IDLE;
               flag_error(ERR_START);
            end else if (b == cfg_eot) begin
               parse_st = PS_IDLE;
               if (fill_level == 0)
                  frame_words_due.push_back(make_word(KIND_EMPTY, '0, 1'b1, '0, NO_CODE));
               for (int i = 0; i < fill_level; i++)
                  frame_words_due.push_back(make_word(KIND_BYTE, frame_bytes[i],
                     i == fill_level - 1, LEN_W'(fill_level), NO_CODE));
               fill_level = 0;
            end else if (b == cfg_esc) begin
               parse_st = PS_ESC;
            end else if (!buffer_byte(b)) begin
               flag_error(ERR_OVER);
            end
         end
         PS_ESC: begin
            if (is_ctrl(b)) begin
               parse_st = PS_FRAME;
               if (!buffer_byte(b))
                  flag_error(ERR_OVER);
            end else begin
               flag_error(ERR_ESCAPE);
            end
         end
         default: parse_st = (b == cfg_soh) ? PS_FRAME : PS_IDLE;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_mismatch(string what, logic [TALLY_W-1:0] got,
                                logic [TALLY_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (frame_words_due.size() == 0) begin
            flag_mismatch("word with none due", TALLY_W'(rsp_kind), '0);
         end else begin
            due_word = frame_words_due.pop_front();
            if (rsp_kind !== due_word.kind)
               flag_mismatch("kind", TALLY_W'(rsp_kind), TALLY_W'(due_word.kind));
            if (rsp_payload !== due_word.payload)
               flag_mismatch("payload", TALLY_W'(rsp_payload), TALLY_W'(due_word.payload));
            if (rsp_last !== due_word.last)
               flag_mismatch("last", TALLY_W'(rsp_last), TALLY_W'(due_word.last));
            if (rsp_frame_length !== due_word.length)
               flag_mismatch("frame_length", TALLY_W'(rsp_frame_length),
                             TALLY_W'(due_word.length));
            if (rsp_fault_code !== due_word.code)
               flag_mismatch("fault_code", TALLY_W'(rsp_fault_code), TALLY_W'(due_word.code));
            if (rsp_error_total !== due_word.total)
               flag_mismatch("error_total", rsp_error_total, due_word.total);
         end
      end
   end

   // result side: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_rx_byte <= BYTE_W'($urandom);
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      deframe_byte(b);
   endtask

   // drop valid, wait out every due word, then let the parser go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (frame_words_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [BYTE_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      if (idx == CSR_CAPACITY)
         data[LEN_W-1:0] = value[LEN_W-1:0];
      else
         data[BYTE_W-1:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_CAPACITY:   cfg_cap = data[LEN_W-1:0];
         CSR_START_CODE: cfg_soh = data[BYTE_W-1:0];
         CSR_END_CODE:   cfg_eot = data[BYTE_W-1:0];
         default:        cfg_esc = data[BYTE_W-1:0];
      endcase
   endtask

   task automatic set_codes(input logic [BYTE_W-1:0] cap, input logic [BYTE_W-1:0] soh,
                            input logic [BYTE_W-1:0] eot, input logic [BYTE_W-1:0] esc);
      settle();
      csr_write(CSR_CAPACITY, cap);
      csr_write(CSR_START_CODE, soh);
      csr_write(CSR_END_CODE, eot);
      csr_write(CSR_ESCAPE_CODE, esc);
   endtask

   task automatic set_idling(input int send_pct, input int hold_pct);
      send_idle_pct = send_pct;
      stall_pct = hold_pct;
   endtask

   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(255)); while (is_ctrl(b));
      return b;
   endfunction

   // escape control values so the payload stays literal
   task automatic send_payload(input int len);
      logic [BYTE_W-1:0] b;
      for (int i = 0; i < len; i++) begin
         b = BYTE_W'($urandom_range(255));
         if (is_ctrl(b))
            push_byte(cfg_esc);
         push_byte(b);
      end
   endtask

   task automatic send_frame(input int len);
      push_byte(cfg_soh);
      send_payload(len);
      push_byte(cfg_eot);
   endtask

   function automatic int pick_length();
      if ($urandom_range(99) < 80)
         return $urandom_range(6);
      return $urandom_range(room_limit() + 2);
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_directed_framing();
      set_idling(0, 0);
      set_codes(CAPACITY_RST, START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
      push_byte(8'h00); push_byte(8'hFF);
      push_byte(cfg_soh); push_byte(cfg_eot);
      push_byte(cfg_soh); push_byte(8'h00); push_byte(8'hFF);
      push_byte(cfg_esc); push_byte(cfg_soh); push_byte(cfg_esc); push_byte(cfg_eot);
      push_byte(cfg_esc); push_byte(cfg_esc); push_byte(cfg_eot);
      push_byte(cfg_soh); push_byte(8'h55); push_byte(cfg_soh);
      push_byte(cfg_soh); push_byte(cfg_esc); push_byte(8'hAA); push_byte(8'h42);
      push_byte(cfg_eot); push_byte(cfg_eot);
   endtask

   task automatic test_capacity_limits();
      set_idling(25, 25);
      set_codes(8'd1, START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
      push_byte(cfg_soh); push_byte(8'h11); push_byte(8'h22); push_byte(cfg_eot);
      push_byte(cfg_soh); push_byte(8'h33); push_byte(cfg_eot);
      set_codes(8'd0, START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
      push_byte(cfg_soh); push_byte(8'h44); push_byte(cfg_esc); push_byte(cfg_esc);
      push_byte(cfg_eot);
      set_codes(8'd64, START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
      push_byte(cfg_soh);
      repeat (BUF_DEPTH) push_byte(plain_byte());
      push_byte(cfg_eot);
      // capacity beyond the buffer clips to the buffer depth
      set_codes(8'd127, START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
      push_byte(cfg_soh);
      repeat (BUF_DEPTH + 2) push_byte(plain_byte());
      push_byte(cfg_eot);
   endtask

   task automatic test_capacity_lowered();
      set_idling(0, 0);
      set_codes(8'd64, START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
      push_byte(cfg_soh);
      repeat (10) push_byte(plain_byte());
      settle();
      csr_write(CSR_CAPACITY, 8'd5);
      repeat (3) push_byte(plain_byte());
      push_byte(cfg_eot);
   endtask

   task automatic test_overlapping_codes();
      set_idling(0, 0);
      // end and escape share a value: end wins
      set_codes(8'd64, 8'h01, 8'h10, 8'h10);
      push_byte(cfg_soh); push_byte(8'h22); push_byte(8'h10);
      // start and end share a value: start wins
      set_codes(8'd64, 8'h20, 8'h20, 8'h30);
      push_byte(8'h20); push_byte(8'h55); push_byte(8'h20);
      push_byte(8'h20); push_byte(8'h30); push_byte(8'h20); push_byte(8'h20);
      // start and escape share a value
      set_codes(8'd64, 8'h40, 8'h04, 8'h40);
      push_byte(8'h40); push_byte(8'h66); push_byte(8'h40);
   endtask

   task automatic test_backpressure();
      set_idling(0, 0);
      set_codes(8'd64, START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
      hold_cycles <= 300;
      repeat (4) send_frame(12);
   endtask

   task automatic test_random_traffic(input int goal);
      int target;
      int pick;
      target = busy_items + goal;
      while (busy_items < target) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            send_frame(pick_length());
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 3)) push_byte(BYTE_W'($urandom_range(255)));
         end else if (pick < 83) begin
            push_byte(cfg_soh);
            send_payload(pick_length());
            push_byte(cfg_soh);
         end else if (pick < 91) begin
            push_byte(cfg_soh);
            send_payload(pick_length());
            push_byte(cfg_esc);
            repeat ($urandom_range(1, 2)) push_byte(plain_byte());
            case ($urandom_range(2))
               0: push_byte(cfg_soh);
               1: push_byte(cfg_eot);
               default: push_byte(cfg_esc);
            endcase
            push_byte(cfg_eot);
         end else begin
            push_byte(cfg_soh);
            send_payload(pick_length());
            repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(255)));
            push_byte(cfg_eot);
         end
      end
   endtask

   task automatic test_random_phases();
      logic [BYTE_W-1:0] s;
      logic [BYTE_W-1:0] e;
      logic [BYTE_W-1:0] x;
      set_idling(0, 0);
      set_codes(8'd64, START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
      test_random_traffic(45);
      set_idling(62, 0);
      set_codes(8'd8, 8'h00, 8'hFF, 8'h80);
      test_random_traffic(45);
      set_idling(0, 62);
      set_codes(8'd127, 8'hFF, 8'h00, 8'h7F);
      test_random_traffic(45);
      s = BYTE_W'($urandom_range(255));
      do e = BYTE_W'($urandom_range(255)); while (e == s);
      do x = BYTE_W'($urandom_range(255)); while (x == s || x == e);
      set_idling(25, 25);
      set_codes(BYTE_W'($urandom_range(1, 64)), s, e, x);
      test_random_traffic(45);
   endtask

   // a run of non-control bytes after an escape raises one error each
   task automatic test_escape_error_run();
      set_idling(0, 0);
      set_codes(8'd64, START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
      push_byte(cfg_soh);
      push_byte(cfg_esc);
      repeat (12) push_byte(plain_byte());
      push_byte(cfg_eot);
      push_byte(cfg_eot);
   endtask

   initial begin
      cfg_cap    = CAPACITY_RST;
      cfg_soh    = START_CODE_RST;
      cfg_eot    = END_CODE_RST;
      cfg_esc    = ESCAPE_CODE_RST;
      parse_st   = PS_IDLE;
      fill_level = 0;
      err_total  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_framing();
      test_capacity_limits();
      test_capacity_lowered();
      test_overlapping_codes();
      test_backpressure();
      test_random_phases();
      test_escape_error_run();
      settle();
      if (mismatch_count == 0)
         $display("escape_framed_byte_deframer: match");
      else
         $display("escape_framed_byte_deframer: mismatch");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("escape_framed_byte_deframer: mismatch");
      $finish;
   end

endmodule
